// File: sv/positioned_char_frame_to_ansi_cursor_unit_macros.svh
// Assertion macros shared by the checker of the cursor escape unit.
`ifndef POSITIONED_CHAR_FRAME_TO_ANSI_CURSOR_UNIT_MACROS_SVH
`define POSITIONED_CHAR_FRAME_TO_ANSI_CURSOR_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define PCFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcfa checker: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define PCFA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcfa checker: same-cycle property failed");

`endif

// File: sv/pcfa_pkg.sv
// Package with the types, constants and digit function of the cursor escape unit.
`timescale 1ns / 1ps
`default_nettype none
package pcfa_pkg;

  localparam logic [7:0] FRAME_MARK = 8'hFF;
  localparam logic [7:0] ESC_CHAR   = 8'h1B;
  localparam logic [7:0] LBRACK     = 8'h5B;
  localparam logic [7:0] SEMI_CHAR  = 8'h3B;
  localparam logic [7:0] CUP_CHAR   = 8'h48;
  localparam logic [3:0] DIGIT_HI   = 4'h3;

  // The queue depth must be a power of two so that the pointers wrap.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COLUMN,
    PH_ROW,
    PH_CHAR
  } phase_e;

  typedef enum logic [3:0] {
    ST_ESC,
    ST_LBRACK,
    ST_ROW_H,
    ST_ROW_T,
    ST_ROW_U,
    ST_SEMI,
    ST_COL_H,
    ST_COL_T,
    ST_COL_U,
    ST_CUP,
    ST_CHAR
  } step_e;

  typedef struct packed {
    logic       is_frame;
    logic [7:0] char_byte;
    logic [7:0] row_byte;
    logic [7:0] column_byte;
  } cmd_t;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  // Splits a byte into three decimal digits; tens use a reciprocal multiply.
  function automatic digits_t dec3(input logic [7:0] v);
    digits_t    d;
    logic [7:0] rem8;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [7:0] tens10;
    if (v >= 8'd200) begin
      d.hundreds = 4'd2;
      rem8 = v - 8'd200;
    end else if (v >= 8'd100) begin
      d.hundreds = 4'd1;
      rem8 = v - 8'd100;
    end else begin
      d.hundreds = 4'd0;
      rem8 = v;
    end
    rem = rem8[6:0];
    prod = 15'(rem) * 15'd205;
    d.tens = prod[14:11];
    tens10 = 8'(d.tens) * 8'd10;
    rem8 = {1'b0, rem} - tens10;
    d.units = rem8[3:0];
    return d;
  endfunction

endpackage
`default_nettype wire

// File: sv/pcfa_front.sv
// Front end: accepts input items, tracks the frame phase and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module pcfa_front
  import pcfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       push_cmd_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] column_q, column_d;
  logic [7:0] row_q, row_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    phase_d  = phase_q;
    column_d = column_q;
    row_d    = row_q;
    if (accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (in_byte_i == FRAME_MARK) begin
            phase_d = PH_COLUMN;
          end
        end
        PH_COLUMN: begin
          column_d = in_byte_i;
          phase_d  = PH_ROW;
        end
        PH_ROW: begin
          row_d   = in_byte_i;
          phase_d = PH_CHAR;
        end
        PH_CHAR: begin
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    push_o                 = 1'b0;
    push_cmd_o.is_frame    = (phase_q == PH_CHAR);
    push_cmd_o.char_byte   = in_byte_i;
    push_cmd_o.row_byte    = row_q;
    push_cmd_o.column_byte = column_q;
    unique case (phase_q)
      PH_IDLE: begin
        push_o = accept && (in_byte_i != FRAME_MARK);
      end
      PH_CHAR: begin
        push_o = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      column_q <= 8'd0;
      row_q    <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/pcfa_queue.sv
// Short command queue between the front end and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module pcfa_queue
  import pcfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic head_valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t           entry_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q;
  logic [QAW-1:0] rd_ptr_q;
  logic [QCW-1:0] count_q;
  logic           do_push;
  logic           do_pop;

  assign full_o       = (count_q == QCW'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/pcfa_back.sv
// Back end: sequences the output bytes of each command into the output register.
`timescale 1ns / 1ps
`default_nettype none
module pcfa_back
  import pcfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  step_e      step_q, step_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load;
  logic [7:0] byte_d;
  logic       last_d;
  digits_t    row_dig;
  digits_t    col_dig;

  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign row_dig = dec3(head_i.row_byte);
  assign col_dig = dec3(head_i.column_byte);

  always_comb begin
    step_d = step_q;
    if (load && head_i.is_frame) begin
      unique case (step_q)
        ST_ESC:    step_d = ST_LBRACK;
        ST_LBRACK: step_d = ST_ROW_H;
        ST_ROW_H:  step_d = ST_ROW_T;
        ST_ROW_T:  step_d = ST_ROW_U;
        ST_ROW_U:  step_d = ST_SEMI;
        ST_SEMI:   step_d = ST_COL_H;
        ST_COL_H:  step_d = ST_COL_T;
        ST_COL_T:  step_d = ST_COL_U;
        ST_COL_U:  step_d = ST_CUP;
        ST_CUP:    step_d = ST_CHAR;
        ST_CHAR:   step_d = ST_ESC;
        default:   step_d = ST_ESC;
      endcase
    end
  end

  always_comb begin
    byte_d = head_i.char_byte;
    last_d = 1'b1;
    if (head_i.is_frame) begin
      last_d = 1'b0;
      unique case (step_q)
        ST_ESC:    byte_d = ESC_CHAR;
        ST_LBRACK: byte_d = LBRACK;
        ST_ROW_H:  byte_d = {DIGIT_HI, row_dig.hundreds};
        ST_ROW_T:  byte_d = {DIGIT_HI, row_dig.tens};
        ST_ROW_U:  byte_d = {DIGIT_HI, row_dig.units};
        ST_SEMI:   byte_d = SEMI_CHAR;
        ST_COL_H:  byte_d = {DIGIT_HI, col_dig.hundreds};
        ST_COL_T:  byte_d = {DIGIT_HI, col_dig.tens};
        ST_COL_U:  byte_d = {DIGIT_HI, col_dig.units};
        ST_CUP:    byte_d = CUP_CHAR;
        ST_CHAR: begin
          byte_d = head_i.char_byte;
          last_d = 1'b1;
        end
        default: begin
          byte_d = head_i.char_byte;
          last_d = 1'b1;
        end
      endcase
    end
    pop_o = load && last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_ESC;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_d;
      out_last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// File: sv/positioned_char_frame_to_ansi_cursor_unit.sv
// Top level of the positioned-character to cursor escape sequence unit.
// Input channel: in_valid_i / in_stall_o with one byte per item on in_byte_i.
// A byte other than 0xFF outside a frame passes through as one output item.
// 0xFF opens a frame of marker, column, row and character; the character
// produces ESC '[' row(3 digits) ';' column(3 digits) 'H' character.
// Output channel: out_valid_o / out_stall_i with out_byte_o and out_last_o;
// out_last_o marks the final byte produced for one input item.
// A pushed command is written into the queue, then loaded into the output register.
// The output sequencer emits one byte per cycle while the receiver does not
// stall, so a full frame of four input items produces eleven output bytes.
// Input items are accepted every cycle while the four-entry command queue
// has room; the queue fills only while the sequencer is busy or stalled.
// When the receiver stalls, the output register holds its byte and the
// queue absorbs new commands until full, then in_stall_o rises.
// Reset clears the frame phase, coordinates, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none
module positioned_char_frame_to_ansi_cursor_unit
  import pcfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head;
  logic pop;

  pcfa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  pcfa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  pcfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

endmodule
`default_nettype wire

// File: sv/pcfa_checker.sv
// Port-level checker of the cursor escape unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "positioned_char_frame_to_ansi_cursor_unit_macros.svh"
module pcfa_checker
  import pcfa_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  logic out_take;
  logic out_held;
  logic is_digit;
  logic is_hundreds;
  logic is_escape_byte;
  logic esc_taken;
  logic bracket_taken;
  logic mid_sequence;

  assign out_take       = out_valid_o && !out_stall_i;
  assign out_held       = out_valid_o && out_stall_i;
  assign is_digit       = (out_byte_o[7:4] == DIGIT_HI) && (out_byte_o[3:0] <= 4'd9);
  assign is_hundreds    = (out_byte_o[7:4] == DIGIT_HI) && (out_byte_o[3:0] <= 4'd2);
  assign is_escape_byte = (out_byte_o == ESC_CHAR) || (out_byte_o == LBRACK) ||
                          (out_byte_o == SEMI_CHAR) || (out_byte_o == CUP_CHAR) || is_digit;
  assign esc_taken      = out_take && !out_last_o && (out_byte_o == ESC_CHAR);
  assign bracket_taken  = out_take && !out_last_o && (out_byte_o == LBRACK);
  assign mid_sequence   = out_valid_o && !out_last_o;

  `PCFA_ASSERT_NEXT(a_out_valid_held, out_held, out_valid_o)
  `PCFA_ASSERT_NEXT(a_out_data_held, out_held, $stable(out_byte_o) && $stable(out_last_o))
  `PCFA_ASSERT_NEXT(a_esc_then_bracket, esc_taken, out_valid_o && out_byte_o == LBRACK)
  `PCFA_ASSERT_NEXT(a_bracket_then_digit, bracket_taken, out_valid_o && is_hundreds)
  `PCFA_ASSERT_SAME(a_escape_byte_set, mid_sequence, is_escape_byte)

endmodule

bind positioned_char_frame_to_ansi_cursor_unit pcfa_checker u_pcfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);
`default_nettype wire

// File: tb/cursor_escape_checker.sv
// Checker that predicts and compares the output items of the cursor escape unit.
`timescale 1ns / 1ps
module cursor_escape_checker
  import pcfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_item_t;

  tx_item_t   expected_tx[$];
  phase_e     frame_phase  = PH_IDLE;
  logic [7:0] frame_column = '0;
  logic [7:0] frame_row    = '0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  task automatic push_tx(input logic [7:0] data, input logic last);
    tx_item_t item;
    item.data = data;
    item.last = last;
    expected_tx.push_back(item);
  endtask

  task automatic push_decimal(input logic [7:0] v);
    push_tx(ASCII_ZERO + v / 8'd100, 1'b0);
    push_tx(ASCII_ZERO + (v / 8'd10) % 8'd10, 1'b0);
    push_tx(ASCII_ZERO + v % 8'd10, 1'b0);
  endtask

  task automatic encode_rx_byte(input logic [7:0] b);
    case (frame_phase)
      PH_IDLE: begin
        if (b == FRAME_MARK) begin
          frame_phase = PH_COLUMN;
        end else begin
          push_tx(b, 1'b1);
        end
      end
      PH_COLUMN: begin
        frame_column = b;
        frame_phase = PH_ROW;
      end
      PH_ROW: begin
        frame_row = b;
        frame_phase = PH_CHAR;
      end
      default: begin
        push_tx(ESC_CHAR, 1'b0);
        push_tx(LBRACK, 1'b0);
        push_decimal(frame_row);
        push_tx(SEMI_CHAR, 1'b0);
        push_decimal(frame_column);
        push_tx(CUP_CHAR, 1'b0);
        push_tx(b, 1'b1);
        frame_phase = PH_IDLE;
      end
    endcase
  endtask

  always @(posedge clk_i) begin : monitor
    tx_item_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_tx.size() == 0) begin
          $display("%0t: unexpected output item: expected none, actual byte %02h last %b",
                   $time, out_byte_i, out_last_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_tx.pop_front();
          if (out_byte_i !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_byte_i);
            fail_count_o = fail_count_o + 1;
          end
          if (out_last_i !== want.last) begin
            $display("%0t: out_last mismatch: expected %b, actual %b",
                     $time, want.last, out_last_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        encode_rx_byte(in_byte_i);
      end
      pending_o = expected_tx.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the testbench: clock, reset, stimulus, watchdog and verdict for the cursor escape unit.
`timescale 1ns / 1ps
module testbench;
  import pcfa_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 155;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  int         failures;
  int         pending;
  int         idle_pct  = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;

  logic [7:0] directed[$] = '{
    8'h00, 8'h7F, 8'h80, 8'hFE, 8'h41,
    8'hFF, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hC7, 8'h64, 8'h20,
    8'hFF, 8'h09, 8'h0A, 8'h7E,
    8'hFF, 8'h2A, 8'hC8, 8'hFF
  };

  positioned_char_frame_to_ansi_cursor_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last)
  );

  cursor_escape_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .out_last_i   (out_last),
    .fail_count_o (failures),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      send_byte(directed[i]);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (sent * 4 / RANDOM_ITEMS)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      if ($urandom_range(0, 9) < 7) begin
        send_byte(FRAME_MARK);
        send_byte(pick_byte());
        send_byte(pick_byte());
        send_byte(pick_byte());
        sent = sent + 4;
      end else begin
        send_byte(8'($urandom_range(0, 254)));
        sent = sent + 1;
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    stall_pct = 0;
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/pcfa_pkg.sv
sv/pcfa_front.sv
sv/pcfa_queue.sv
sv/pcfa_back.sv
sv/positioned_char_frame_to_ansi_cursor_unit.sv
sv/pcfa_checker.sv
tb/cursor_escape_checker.sv
tb/testbench.sv
